### rtl/htw_pkg.sv
// Shared constants and types for the hashed timer wheel.
package htw_pkg;

   localparam int MAX_TIMERS_DEF = 64;
   localparam int CMD_W = 1;
   localparam int ID_W = 16;
   localparam int IVL_W = 32;
   localparam int PER_W = 16;
   localparam int KIND_W = 3;
   localparam int CNT_W = 32;
   localparam logic [PER_W-1:0] PERIOD_RST = 16'd10;

   localparam logic [CMD_W-1:0] CMD_ADD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ADD_OK = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ZERO = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIRED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_IDLE = 3'd4;

   // One stored timer as held by a cell of the row.
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] expiry;
      logic [ID_W-1:0]  ident;
   } timer_type;

endpackage

### rtl/htw_div.sv
// Bit-serial restoring divider: interval by tick period.
module htw_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [htw_pkg::IVL_W-1:0]   dividend,
   input  logic [htw_pkg::PER_W-1:0]   divisor,
   output logic                        done,
   output logic [htw_pkg::IVL_W-1:0]   quotient
);
   localparam int IW = htw_pkg::IVL_W;
   localparam int PW = htw_pkg::PER_W;
   localparam int SW = $clog2(IW + 1);

   logic [PW:0]     rem_ff, rem_in;
   logic [IW-1:0]   quo_ff, quo_in;
   logic [PW-1:0]   dvs_ff, dvs_in;
   logic [SW-1:0]   step_ff, step_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [PW:0]     trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[PW-1:0], quo_ff[IW-1]};
      if (go) begin
         rem_in  = '0;
         quo_in  = dividend;
         // treat a zero period as one
         dvs_in  = (divisor == '0) ? PW'(1) : divisor;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[IW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[IW-2:0], 1'b0};
         end
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(IW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

### rtl/htw_cell.sv
// One timer cell of the row: holds one timer and takes its right neighbor on a shift.
module htw_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic                 load,
   input  htw_pkg::timer_type   load_data,
   input  htw_pkg::timer_type   from_right,
   output htw_pkg::timer_type   data
);
   htw_pkg::timer_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (shift) data_in = from_right;
      // a load wins over the shift: the kept head lands here
      if (load) data_in = load_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;
endmodule

### rtl/hashed_timer_wheel.sv
// Hashed timer wheel top level: command decode, divider, timer cell row.
//
// Usage: pulse start with req_cmd, req_timer_id, req_interval_ms while busy
// is low. An add computes floor(interval / period) with a bit-serial
// divider and answers with one rsp_ beat; busy falls in the cycle in
// which that beat is valid. A tick rotates the stored timers through the
// head cell, one per cycle: a timer whose expiry equals the tick count is
// dropped and reported, any other goes back to the end of the row. One
// fired beat is held until the next one or the end so the final beat
// carries rsp_last; with no timer fired a single idle beat goes out.
// Beats appear for one cycle under rsp_valid; the receiver cannot stall.
// The row keeps insertion order, and every timer due on a tick sits in that
// tick's bucket, so the row gives the bucket order for every bucket.
// csr_we writes the tick period; write only while busy is low.
// Reset empties the row, clears the tick count and sets the period to 10 ms.
module hashed_timer_wheel #(
   parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [htw_pkg::CMD_W-1:0]    req_cmd,
   input  logic [htw_pkg::ID_W-1:0]     req_timer_id,
   input  logic [htw_pkg::IVL_W-1:0]    req_interval_ms,
   output logic                         rsp_valid,
   output logic [htw_pkg::KIND_W-1:0]   rsp_kind,
   output logic [htw_pkg::ID_W-1:0]     rsp_fired_id,
   output logic                         rsp_last,
   input  logic                         csr_we,
   input  logic [htw_pkg::PER_W-1:0]    csr_wdata
);
   localparam int N = MAX_TIMERS;
   localparam int CW = htw_pkg::CNT_W;
   localparam int IW = htw_pkg::ID_W;
   localparam int PW = $clog2(N + 1);
   localparam int IXW = (N > 1) ? $clog2(N) : 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_ADD  = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type                  st_ff, st_in;
   logic [htw_pkg::PER_W-1:0]  per_ff, per_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [IW-1:0]              id_ff, id_in;
   logic [PW-1:0]              fill_ff, fill_in;
   logic [PW-1:0]              left_ff, left_in;
   logic                       pend_v_ff, pend_v_in;
   logic [IW-1:0]              pend_id_ff, pend_id_in;
   logic                       out_v_ff, out_v_in;
   logic                       out_l_ff, out_l_in;
   logic [htw_pkg::KIND_W-1:0] out_k_ff, out_k_in;
   logic [IW-1:0]              out_id_ff, out_id_in;
   logic                       div_go, div_done;
   logic [CW-1:0]              quo;

   logic                       shift;
   logic                       load_en;
   logic [IXW-1:0]             load_idx;
   htw_pkg::timer_type         load_data;
   htw_pkg::timer_type         head;
   htw_pkg::timer_type         row [N];
   htw_pkg::timer_type         right [N];
   logic [N-1:0]               used;

   htw_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(req_interval_ms),
      .divisor(per_ff), .done(div_done), .quotient(quo)
   );

   for (genvar k = 0; k < N; k++) begin : g_row
      if (k == N - 1) begin : g_tail
         assign right[k] = '0;
      end else begin : g_link
         assign right[k] = row[k + 1];
      end
      assign used[k] = row[k].valid;
      htw_cell u_cell (
         .clock(clock), .reset(reset), .shift(shift),
         .load(load_en && (load_idx == IXW'(k))), .load_data(load_data),
         .from_right(right[k]), .data(row[k])
      );
   end

   assign head = row[0];
   assign div_go = (st_ff == ST_IDLE) && start && (req_cmd == htw_pkg::CMD_ADD);
   assign busy = (st_ff != ST_IDLE);

   always_comb begin
      st_in      = st_ff;
      per_in     = per_ff;
      cnt_in     = cnt_ff;
      id_in      = id_ff;
      fill_in    = fill_ff;
      left_in    = left_ff;
      pend_v_in  = pend_v_ff;
      pend_id_in = pend_id_ff;
      out_v_in   = 1'b0;
      out_l_in   = out_l_ff;
      out_k_in   = out_k_ff;
      out_id_in  = out_id_ff;
      shift      = 1'b0;
      load_en    = 1'b0;
      load_idx   = '0;
      load_data  = '0;
      if (csr_we) per_in = csr_wdata;
      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               id_in = req_timer_id;
               if (req_cmd == htw_pkg::CMD_ADD) begin
                  st_in = ST_DIV;
               end else begin
                  st_in = ST_SCAN;
                  left_in = fill_ff;
                  pend_v_in = 1'b0;
               end
            end
         end
         ST_DIV: begin
            if (div_done) st_in = ST_ADD;
         end
         ST_ADD: begin
            st_in = ST_IDLE;
            out_v_in = 1'b1;
            out_l_in = 1'b1;
            out_id_in = '0;
            if (quo == '0) begin
               out_k_in = htw_pkg::KIND_ZERO;
            end else if (fill_ff == PW'(N)) begin
               out_k_in = htw_pkg::KIND_FULL;
            end else begin
               out_k_in = htw_pkg::KIND_ADD_OK;
               load_en = 1'b1;
               load_idx = IXW'(fill_ff);
               load_data.valid = 1'b1;
               load_data.expiry = cnt_ff + quo;
               load_data.ident = id_ff;
               fill_in = fill_ff + PW'(1);
            end
         end
         ST_SCAN: begin
            if (left_ff == '0) begin
               st_in = ST_FIN;
            end else begin
               // advance the row; the head either leaves or goes to the end
               shift = 1'b1;
               left_in = left_ff - PW'(1);
               if (head.expiry == cnt_ff) begin
                  fill_in = fill_ff - PW'(1);
                  if (pend_v_ff) begin
                     out_v_in = 1'b1;
                     out_k_in = htw_pkg::KIND_FIRED;
                     out_id_in = pend_id_ff;
                     out_l_in = 1'b0;
                  end
                  pend_v_in = 1'b1;
                  pend_id_in = head.ident;
               end else begin
                  load_en = 1'b1;
                  load_idx = IXW'(fill_ff - PW'(1));
                  load_data = head;
               end
            end
         end
         ST_FIN: begin
            st_in = ST_IDLE;
            cnt_in = cnt_ff + CW'(1);
            out_v_in = 1'b1;
            out_l_in = 1'b1;
            pend_v_in = 1'b0;
            if (pend_v_ff) begin
               out_k_in = htw_pkg::KIND_FIRED;
               out_id_in = pend_id_ff;
            end else begin
               out_k_in = htw_pkg::KIND_IDLE;
               out_id_in = '0;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         per_ff <= htw_pkg::PERIOD_RST;
         cnt_ff <= '0;
         id_ff <= '0;
         fill_ff <= '0;
         left_ff <= '0;
         pend_v_ff <= 1'b0;
         pend_id_ff <= '0;
         out_v_ff <= 1'b0;
         out_l_ff <= 1'b0;
         out_k_ff <= '0;
         out_id_ff <= '0;
      end else begin
         st_ff <= st_in;
         per_ff <= per_in;
         cnt_ff <= cnt_in;
         id_ff <= id_in;
         fill_ff <= fill_in;
         left_ff <= left_in;
         pend_v_ff <= pend_v_in;
         pend_id_ff <= pend_id_in;
         out_v_ff <= out_v_in;
         out_l_ff <= out_l_in;
         out_k_ff <= out_k_in;
         out_id_ff <= out_id_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = out_k_ff;
   assign rsp_fired_id = out_id_ff;
   assign rsp_last = out_l_ff;

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= PW'(N)) else $error("fill over capacity");
   assert property (@(posedge clock) disable iff (reset)
      $countones(used) == int'(fill_ff)) else $error("fill mismatch");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FIN) |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("tick count did not advance");
endmodule
